### rtl/mexp_pkg.sv
// mexp_pkg: shared widths, register indexes, microcode word layout and the
// control program of the modular exponentiation decrypt block
// no dependencies
`timescale 1ns / 1ps

package mexp_pkg;

   localparam int MOD_WIDTH    = 32;
   localparam int CIPHER_WIDTH = 63;
   localparam int CSR_WIDTH    = 32;
   localparam int VALUE_WIDTH  = 32;
   localparam int BYTE_WIDTH   = 8;
   localparam int CNT_WIDTH    = $clog2(CIPHER_WIDTH + 1);

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_EXPONENT = 1'b0;
   localparam csr_index_type CSR_MODULUS  = 1'b1;

   typedef logic [2:0] step_type;
   localparam step_type STEP_IDLE   = 3'd0;
   localparam step_type STEP_REDUCE = 3'd1;
   localparam step_type STEP_TEST_Z = 3'd2;
   localparam step_type STEP_TEST_B = 3'd3;
   localparam step_type STEP_MUL    = 3'd4;
   localparam step_type STEP_SQR    = 3'd5;
   localparam step_type STEP_EMIT   = 3'd6;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_REDUCE,
      MUL_ACC,
      MUL_SQR
   } mul_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_EXP_ZERO,
      JMP_EXP_EVEN
   } jump_type;

   typedef struct packed {
      logic       wait_req;
      mul_op_type mul_op;
      logic       emit;
      jump_type   jump;
      step_type   target;
   } ucode_type;

   typedef struct packed {
      logic       req_ready;
      logic       load;
      mul_op_type mul_op;
      logic       mul_start;
      logic       mul_commit;
      logic       out_load;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic mul_done;
      logic exp_zero;
      logic exp_odd;
      logic out_free;
   } status_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      case (step)
         STEP_IDLE:   word = '{1'b1, MUL_NONE,   1'b0, JMP_NEXT,     STEP_IDLE};
         STEP_REDUCE: word = '{1'b0, MUL_REDUCE, 1'b0, JMP_NEXT,     STEP_IDLE};
         STEP_TEST_Z: word = '{1'b0, MUL_NONE,   1'b0, JMP_EXP_ZERO, STEP_EMIT};
         STEP_TEST_B: word = '{1'b0, MUL_NONE,   1'b0, JMP_EXP_EVEN, STEP_SQR};
         STEP_MUL:    word = '{1'b0, MUL_ACC,    1'b0, JMP_NEXT,     STEP_IDLE};
         STEP_SQR:    word = '{1'b0, MUL_SQR,    1'b0, JMP_ALWAYS,   STEP_TEST_Z};
         STEP_EMIT:   word = '{1'b0, MUL_NONE,   1'b1, JMP_ALWAYS,   STEP_IDLE};
         default:     word = '{1'b0, MUL_NONE,   1'b0, JMP_ALWAYS,   STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

### rtl/mexp_mulmod.sv
// mexp_mulmod: bit-serial interleaved modular multiplier, one multiplier bit
// per cycle, msb first; depends on mexp_pkg
`timescale 1ns / 1ps

module mexp_mulmod (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [mexp_pkg::MOD_WIDTH-1:0]        a,
   input  logic [mexp_pkg::CIPHER_WIDTH-1:0]     b,
   input  logic [mexp_pkg::CNT_WIDTH-1:0]        len,
   input  logic [mexp_pkg::MOD_WIDTH-1:0]        m,
   output logic                                  done,
   output logic [mexp_pkg::MOD_WIDTH-1:0]        product
);
   import mexp_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [MOD_WIDTH-1:0]      r_ff, r_in;
   logic [MOD_WIDTH-1:0]      a_ff, a_in;
   logic [CIPHER_WIDTH-1:0]   sh_ff, sh_in;
   logic [CNT_WIDTH-1:0]      cnt_ff, cnt_in;

   logic [MOD_WIDTH:0]        m_ext;
   logic [MOD_WIDTH:0]        dbl;
   logic [MOD_WIDTH:0]        dbl_red;
   logic [MOD_WIDTH:0]        sum;
   logic [MOD_WIDTH:0]        sum_red;

   always_comb begin
      m_ext   = {1'b0, m};
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
      sum     = {1'b0, dbl_red[MOD_WIDTH-1:0]}
              + (sh_ff[CIPHER_WIDTH-1] ? {1'b0, a_ff} : '0);
      sum_red = (sum >= m_ext) ? sum - m_ext : sum;

      busy_in = busy_ff;
      done_in = 1'b0;
      r_in    = r_ff;
      a_in    = a_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         r_in    = '0;
         a_in    = a;
         sh_in   = b;
         cnt_in  = len;
      end else if (busy_ff) begin
         r_in   = sum_red[MOD_WIDTH-1:0];
         sh_in  = {sh_ff[CIPHER_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      r_ff   <= r_in;
      a_ff   <= a_in;
      sh_ff  <= sh_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule

### rtl/mexp_seq.sv
// mexp_seq: microcode sequencer, step counter over the control program in
// mexp_pkg with conditional jumps; depends on mexp_pkg
`timescale 1ns / 1ps

module mexp_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  mexp_pkg::status_type   status,
   output mexp_pkg::ctrl_type     ctrl
);
   import mexp_pkg::*;

   step_type  step_ff, step_in;
   logic      pending_ff, pending_in;
   ucode_type word;
   logic      mul_active;
   logic      go;
   logic      taken;

   always_comb begin
      word       = ucode_rom(step_ff);
      mul_active = (word.mul_op != MUL_NONE);

      go = 1'b1;
      if (word.wait_req) go = status.req_valid;
      if (mul_active)    go = status.mul_done;
      if (word.emit)     go = status.out_free;

      case (word.jump)
         JMP_NEXT:     taken = 1'b0;
         JMP_ALWAYS:   taken = 1'b1;
         JMP_EXP_ZERO: taken = status.exp_zero;
         JMP_EXP_EVEN: taken = ~status.exp_odd;
         default:      taken = 1'b0;
      endcase

      ctrl.req_ready  = word.wait_req;
      ctrl.load       = word.wait_req & status.req_valid;
      ctrl.mul_op     = word.mul_op;
      ctrl.mul_start  = mul_active & ~pending_ff;
      ctrl.mul_commit = mul_active & status.mul_done;
      ctrl.out_load   = word.emit & status.out_free;

      pending_in = pending_ff;
      if (ctrl.mul_start)  pending_in = 1'b1;
      if (ctrl.mul_commit) pending_in = 1'b0;

      step_in = step_ff;
      if (go) begin
         step_in = taken ? word.target : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= STEP_IDLE;
         pending_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         pending_ff <= pending_in;
      end
   end

endmodule

### rtl/modular_exponentiation_decrypt.sv
// modular_exponentiation_decrypt: top level, configuration registers,
// operand registers, output register; uses mexp_seq, mexp_mulmod, mexp_pkg
//
// One ciphertext transaction in, one result transaction out: the word is
// reduced modulo the modulus, then raised to the private exponent by
// right-to-left square-and-multiply. All work runs through one bit-serial
// modular multiplier that handles one multiplier bit per cycle, stepped by a
// small microcoded sequencer; one item is in flight at a time. The time an item
// takes grows with the position of the highest set exponent bit and with the
// number of set exponent bits. A modulus of zero returns zero, an exponent of
// zero returns 1 mod modulus. Registers are to be written only while idle;
// the block itself does not enforce it.
`timescale 1ns / 1ps

module modular_exponentiation_decrypt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mexp_pkg::CIPHER_WIDTH-1:0]   req_cipher_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mexp_pkg::VALUE_WIDTH-1:0]    rsp_plain_value,
   output logic [mexp_pkg::BYTE_WIDTH-1:0]     rsp_plain_byte,
   input  logic                                csr_write_enable,
   input  mexp_pkg::csr_index_type             csr_index,
   input  logic [mexp_pkg::CSR_WIDTH-1:0]      csr_write_data
);
   import mexp_pkg::*;

   logic [CSR_WIDTH-1:0]     exponent_ff, exponent_in;
   logic [CSR_WIDTH-1:0]     modulus_ff, modulus_in;

   logic [CIPHER_WIDTH-1:0]  cipher_ff, cipher_in;
   logic [CSR_WIDTH-1:0]     exp_ff, exp_in;
   logic [MOD_WIDTH-1:0]     acc_ff, acc_in;
   logic [MOD_WIDTH-1:0]     base_ff, base_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]   plain_value_ff, plain_value_in;
   logic [BYTE_WIDTH-1:0]    plain_byte_ff, plain_byte_in;

   logic [MOD_WIDTH-1:0]     m;
   logic                     mod_zero;
   logic                     mod_one;
   logic [MOD_WIDTH-1:0]     result;

   logic [MOD_WIDTH-1:0]     mul_a;
   logic [CIPHER_WIDTH-1:0]  mul_b;
   logic [CNT_WIDTH-1:0]     mul_len;
   logic                     mul_done;
   logic [MOD_WIDTH-1:0]     mul_product;

   ctrl_type                 ctrl;
   status_type               status;

   // configuration registers
   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_EXPONENT: exponent_in = csr_write_data;
            CSR_MODULUS:  modulus_in  = csr_write_data;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= CSR_WIDTH'(1);
         modulus_ff  <= CSR_WIDTH'(1);
      end else begin
         exponent_ff <= exponent_in;
         modulus_ff  <= modulus_in;
      end
   end

   assign m        = modulus_ff[MOD_WIDTH-1:0];
   assign mod_zero = (m == '0);
   assign mod_one  = (m == MOD_WIDTH'(1));

   // multiplier operand selection
   always_comb begin
      case (ctrl.mul_op)
         MUL_REDUCE: begin
            mul_a   = MOD_WIDTH'(1);
            mul_b   = cipher_ff;
            mul_len = CNT_WIDTH'(CIPHER_WIDTH);
         end
         MUL_SQR: begin
            mul_a   = base_ff;
            mul_b   = {base_ff, {(CIPHER_WIDTH - MOD_WIDTH){1'b0}}};
            mul_len = CNT_WIDTH'(MOD_WIDTH);
         end
         default: begin
            mul_a   = acc_ff;
            mul_b   = {base_ff, {(CIPHER_WIDTH - MOD_WIDTH){1'b0}}};
            mul_len = CNT_WIDTH'(MOD_WIDTH);
         end
      endcase
   end

   mexp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (ctrl.mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .len     (mul_len),
      .m       (m),
      .done    (mul_done),
      .product (mul_product)
   );

   assign status.req_valid = req_valid;
   assign status.mul_done  = mul_done;
   assign status.exp_zero  = (exp_ff == '0);
   assign status.exp_odd   = exp_ff[0];
   assign status.out_free  = ~rsp_valid_ff | ~rsp_stall;

   mexp_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // operand registers
   always_comb begin
      cipher_in = cipher_ff;
      exp_in    = exp_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      if (ctrl.load) begin
         cipher_in = req_cipher_word;
         exp_in    = exponent_ff;
         acc_in    = mod_one ? '0 : MOD_WIDTH'(1);
      end
      if (ctrl.mul_commit) begin
         case (ctrl.mul_op)
            MUL_REDUCE: base_in = mul_product;
            MUL_ACC:    acc_in  = mul_product;
            MUL_SQR: begin
               base_in = mul_product;
               exp_in  = {1'b0, exp_ff[CSR_WIDTH-1:1]};
            end
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cipher_ff <= cipher_in;
      exp_ff    <= exp_in;
      acc_ff    <= acc_in;
      base_ff   <= base_in;
   end

   // output register
   assign result = mod_zero ? '0 : acc_ff;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      plain_value_in = plain_value_ff;
      plain_byte_in  = plain_byte_ff;
      if (ctrl.out_load) begin
         rsp_valid_in   = 1'b1;
         plain_value_in = VALUE_WIDTH'(result);
         plain_byte_in  = result[BYTE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      plain_value_ff <= plain_value_in;
      plain_byte_ff  <= plain_byte_in;
   end

   assign req_stall       = ~ctrl.req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_plain_value = plain_value_ff;
   assign rsp_plain_byte  = plain_byte_ff;

endmodule
